// ----- hw/rtl/wabavg_pkg.sv -----
// Package for the weighted axial bin averager: item types, operation and register codes.
// It depends on nothing. Every other file in hw/rtl but wabavg_ram imports it.
package wabavg_pkg;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [31:0]        weight;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
		logic [7:0]         read_index;
	} item_in_t;

	typedef struct packed {
		logic [7:0]         bin_number;
		logic               bin_valid;
		logic signed [31:0] mean_x;
		logic signed [31:0] mean_y;
		logic signed [31:0] mean_z;
		logic [47:0]        total_weight;
	} item_out_t;

	// Operation codes.
	localparam logic [1:0] OP_ACC   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_AXIS_X = 3'd0;
	localparam logic [2:0] CFG_AXIS_Y = 3'd1;
	localparam logic [2:0] CFG_AXIS_Z = 3'd2;
	localparam logic [2:0] CFG_OFFSET = 3'd3;
	localparam logic [2:0] CFG_SCALE  = 3'd4;
	localparam logic [2:0] CFG_BINS   = 3'd5;

	// One bin entry: three component sums and the weight sum.
	localparam int SUM_W  = 64;
	localparam int WT_W   = 48;
	localparam int WORD_W = 3 * SUM_W + WT_W;

	// Width of bin counts and limits; holds a bin count of up to 8191.
	localparam int LIM_W = 13;

endpackage

// ----- hw/rtl/wabavg_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// It depends on nothing.
module wabavg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                        wdata,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- hw/rtl/wabavg_div.sv -----
// Restoring divider: 64-bit unsigned dividend by 48-bit divisor, one quotient bit per cycle.
// It depends on wabavg_pkg.
module wabavg_div
	import wabavg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	input  logic [WT_W-1:0]  divisor,
	output logic             done,
	output logic [SUM_W-1:0] quotient
);
	logic [WT_W-1:0]  rem_q;
	logic [SUM_W-1:0] dvd_q;
	logic [WT_W-1:0]  dvs_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WT_W:0]    rs;
	logic             qbit;

	always_comb begin
		rs   = {rem_q, dvd_q[SUM_W-1]};
		qbit = (rs >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? WT_W'(rs - {1'b0, dvs_q}) : rs[WT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ----- hw/rtl/weighted_axial_bin_averager.sv -----
// Top level of the weighted axial bin averager: binning datapath, bin memory and sequencer.
// It depends on wabavg_pkg, wabavg_ram and wabavg_div.
//
// Usage. Items arrive on in_valid/in_ready/in_data, one beat per item. An accumulate
// beat projects the sample position onto the axis, turns the distance into a bin and
// adds weight*value and the weight into that bin, saturating. A read beat returns one
// beat on out_valid/out_ready/out_data with the bin's weighted means, valid flag and
// weight sum. A clear beat zeroes one bin. Configuration is written on cfg_valid/
// cfg_ready/cfg_index/cfg_data, which is always ready, by the user only while the block
// idles; the block itself does not enforce this. Timing. The block works on one item at
// a time. An accumulate holds in_ready low after its accept through four binning
// stages, then the write-back of the bin word read in the last of them, and no item is
// taken before it is through; a sample outside the active bins frees the block after
// the binning stages. A clear holds in_ready low for its write. A read of a bin
// that holds weight passes the memory read, the divider load, the bit-serial divider
// (64 quotient bits and its done flag), then the output register. A read of an empty
// bin skips the divider, and a read of a bin beyond the memory skips the load too.
// Stalls. The result sits in an output register, so accumulates and clears go on while
// it waits; a second read waits at its end until the first result is taken.
// Reset. After arst_n rises the block sweeps the bin memory, one bin a cycle, with
// in_ready low; configuration writes are taken during that sweep.
module weighted_axial_bin_averager
	import wabavg_pkg::*;
#(
	parameter int BINS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  item_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output item_out_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;

	typedef enum logic [10:0] {
		S_CLR  = 11'b00000000001,
		S_IDLE = 11'b00000000010,
		S_BIN1 = 11'b00000000100,
		S_BIN2 = 11'b00000001000,
		S_BIN3 = 11'b00000010000,
		S_BIN4 = 11'b00000100000,
		S_MOD  = 11'b00001000000,
		S_RD   = 11'b00010000000,
		S_LOAD = 11'b00100000000,
		S_DIV  = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers.
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [31:0] off_q;
	logic [31:0]        bsc_q;
	logic [8:0]         nbin_q;

	// Item and binning pipeline.
	item_in_t           item_q;
	logic signed [47:0] pa_q, pb_q, pc_q;
	logic signed [50:0] d_q;
	logic signed [63:0] wpx_q, wpy_q, wpz_q;
	logic               neg_q;
	logic [50:0]        mh_q;
	logic [31:0]        ml_q;
	logic [63:0]        lo_prod;
	logic [51:0]        bsum;
	logic [37:0]        bin_full;
	logic [LIM_W-1:0]   lim;
	logic               keep;
	logic [AW-1:0]      acc_addr_q;
	logic [AW-1:0]      clr_cnt_q;
	logic               idx_ok;

	// Memory.
	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	logic [WORD_W-1:0]  ram_wdata, ram_rdata;
	logic signed [63:0] rsx, rsy, rsz;
	logic [WT_W-1:0]    rwt;
	logic signed [63:0] nsx, nsy, nsz;
	logic [WT_W:0]      wt_sum;
	logic [WT_W-1:0]    nwt;

	// Read path.
	logic               zero_q;
	logic [WT_W-1:0]    tot_q;
	logic               sgx_q, sgy_q, sgz_q;
	logic               div_start;
	logic               div_done;
	logic [SUM_W-1:0]   qx, qy, qz;
	logic [SUM_W-1:0]   magx, magy, magz;
	logic               out_valid_q;
	item_out_t          out_q, res;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			s = a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end
		return s;
	endfunction

	function automatic logic [31:0] sat_mean(input logic neg, input logic [63:0] q);
		logic [31:0] r;
		if (neg) begin
			r = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
		end else begin
			r = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? 64'd0 - v : v;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q   <= 16'sd16384;
			ay_q   <= '0;
			az_q   <= '0;
			off_q  <= '0;
			bsc_q  <= 32'd65536;
			nbin_q <= 9'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_AXIS_X: ax_q   <= cfg_data[15:0];
				CFG_AXIS_Y: ay_q   <= cfg_data[15:0];
				CFG_AXIS_Z: az_q   <= cfg_data[15:0];
				CFG_OFFSET: off_q  <= cfg_data;
				CFG_SCALE:  bsc_q  <= cfg_data;
				CFG_BINS:   nbin_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Active bin limit: the smaller of the register and the memory depth.
	assign lim    = ({4'b0, nbin_q} > LIM_W'(BINS)) ? LIM_W'(BINS) : {4'b0, nbin_q};
	assign idx_ok = ({5'b0, item_q.read_index} < LIM_W'(BINS));

	// Bin index: floor(d * scale / 2^46) from a high and a low partial product.
	always_comb begin
		lo_prod  = d_q[31:0] * bsc_q;
		bsum     = 52'(mh_q) + 52'(ml_q);
		bin_full = bsum[51:14];
		if (bsc_q == '0) begin
			keep = (lim != '0);
		end else begin
			keep = !neg_q && (bin_full < 38'(lim));
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		pa_q  <= item_q.pos_x * ax_q;
		pb_q  <= item_q.pos_y * ay_q;
		pc_q  <= item_q.pos_z * az_q;
		d_q   <= 51'(pa_q) + 51'(pb_q) + 51'(pc_q) - {{5{off_q[31]}}, off_q, 14'b0};
		wpx_q <= 64'($signed({1'b0, item_q.weight}) * item_q.value_x);
		wpy_q <= 64'($signed({1'b0, item_q.weight}) * item_q.value_y);
		wpz_q <= 64'($signed({1'b0, item_q.weight}) * item_q.value_z);
		neg_q <= d_q[50];
		mh_q  <= d_q[50:32] * bsc_q;
		ml_q  <= lo_prod[63:32];
		if (state_q == S_BIN4) begin
			acc_addr_q <= (bsc_q == '0) ? '0 : bin_full[AW-1:0];
		end
	end

	// Memory word unpacking and the saturating update.
	assign {rwt, rsz, rsy, rsx} = ram_rdata;
	always_comb begin
		nsx    = sat_add(rsx, wpx_q);
		nsy    = sat_add(rsy, wpy_q);
		nsz    = sat_add(rsz, wpz_q);
		wt_sum = {1'b0, rwt} + (WT_W+1)'(item_q.weight);
		nwt    = wt_sum[WT_W] ? {WT_W{1'b1}} : wt_sum[WT_W-1:0];
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '0;
		ram_addr  = AW'(item_q.read_index);
		case (state_q)
			S_CLR: begin
				ram_we   = 1'b1;
				ram_addr = clr_cnt_q;
			end
			S_BIN4: begin
				ram_addr = (bsc_q == '0) ? '0 : bin_full[AW-1:0];
			end
			S_MOD: begin
				ram_we    = 1'b1;
				ram_addr  = acc_addr_q;
				ram_wdata = {nwt, nsz, nsy, nsx};
			end
			S_RD: begin
				ram_we = (item_q.operation == OP_CLEAR) && idx_ok;
			end
			default: ;
		endcase
	end

	wabavg_ram #(
		.WIDTH(WORD_W),
		.DEPTH(BINS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Three divider lanes run in lock step.
	assign div_start = (state_q == S_LOAD) && (rwt != '0);
	assign magx = mag(rsx);
	assign magy = mag(rsy);
	assign magz = mag(rsz);

	wabavg_div u_div_x (.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(magx),
		.divisor(rwt), .done(div_done), .quotient(qx));
	wabavg_div u_div_y (.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(magy),
		.divisor(rwt), .done(), .quotient(qy));
	wabavg_div u_div_z (.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(magz),
		.divisor(rwt), .done(), .quotient(qz));

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			tot_q <= rwt;
			sgx_q <= rsx[63];
			sgy_q <= rsy[63];
			sgz_q <= rsz[63];
		end
		if (state_q == S_RD) begin
			zero_q <= !idx_ok;
		end
	end

	// A result with no weight, or for a bin beyond the memory, is all zero but the bin number.
	always_comb begin
		res              = '0;
		res.bin_number   = item_q.read_index;
		if (!zero_q && tot_q != '0) begin
			res.bin_valid    = 1'b1;
			res.total_weight = tot_q;
			res.mean_x       = sat_mean(sgx_q, qx);
			res.mean_y       = sat_mean(sgy_q, qy);
			res.mean_z       = sat_mean(sgz_q, qz);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR:  state_d = (clr_cnt_q == AW'(BINS - 1)) ? S_IDLE : S_CLR;
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.operation == OP_ACC) ? S_BIN1 : S_RD;
				end
			end
			S_BIN1: state_d = S_BIN2;
			S_BIN2: state_d = S_BIN3;
			S_BIN3: state_d = S_BIN4;
			S_BIN4: state_d = keep ? S_MOD : S_IDLE;
			S_MOD:  state_d = S_IDLE;
			S_RD: begin
				if (item_q.operation == OP_READ) begin
					state_d = idx_ok ? S_LOAD : S_OUT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LOAD: state_d = (rwt != '0) ? S_DIV : S_OUT;
			S_DIV:  state_d = div_done ? S_OUT : S_DIV;
			S_OUT:  state_d = (!out_valid_q || out_ready) ? S_IDLE : S_OUT;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The output register takes a finished result once the previous beat has left.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_q <= res;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hw/rtl/wabavg_chk.sv -----
// Port-level checker for the weighted axial bin averager, bound to the top level.
// It depends on wabavg_pkg and weighted_axial_bin_averager.
module wabavg_chk
	import wabavg_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input item_in_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input item_out_t out_data
);
	// A result beat that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// The valid flag follows the weight sum.
	a_valid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.bin_valid == (out_data.total_weight != '0)))
		else $error("bin_valid disagrees with total_weight");

	// An empty bin reports zero means.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.bin_valid |->
		(out_data.mean_x == 0 && out_data.mean_y == 0 && out_data.mean_z == 0))
		else $error("empty bin with nonzero mean");

	// One item at a time: an accepted beat makes the block busy next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while busy");

	// Nothing is taken while reset is applied.
	a_reset: assert property (@(posedge clk) !arst_n |-> !in_ready)
		else $error("input ready during reset");

endmodule

bind weighted_axial_bin_averager wabavg_chk u_chk (.*);

// ----- test/weighted_axial_bin_averager_tb.sv -----
// Testbench for the weighted axial bin averager: drives accumulate, read and clear beats,
// predicts every read result in the bench and checks the results in order.
// It depends on wabavg_pkg and the weighted_axial_bin_averager top level.
module weighted_axial_bin_averager_tb;
	import wabavg_pkg::*;

	localparam int NBINS = 256;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	item_in_t in_data;
	logic out_valid;
	logic out_ready;
	item_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	weighted_axial_bin_averager #(.BINS(NBINS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Bench copy of the configuration registers.
	logic signed [15:0] ax, ay, az;
	logic signed [31:0] offset_q;
	logic [31:0] scale_q;
	logic [8:0] bins_used;

	// Bench copy of the bin memory.
	logic signed [63:0] sum_x [NBINS];
	logic signed [63:0] sum_y [NBINS];
	logic signed [63:0] sum_z [NBINS];
	logic [47:0] wsum [NBINS];

	item_in_t pending_items[$];
	item_out_t expected_reads[$];
	int mismatches;
	bit pause_req;
	int accepted_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	function automatic logic [31:0] bin_mean(logic signed [63:0] s, logic [47:0] t);
		logic [63:0] mag, q;
		if (t == 0) return 32'd0;
		mag = s[63] ? 64'd0 - s : s;
		q = mag / {16'd0, t};
		if (s[63]) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			return 32'd0 - q[31:0];
		end
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	// Updates the bench bin memory for one beat and, for a read beat, queues its result.
	task automatic predict_beat(item_in_t it);
		logic signed [63:0] proj_d;
		logic [63:0] ud, bin, lim;
		logic [95:0] prod;
		logic [47:0] tot;
		logic [48:0] wt;
		item_out_t r;
		case (it.operation)
			OP_ACC: begin
				proj_d = 64'(it.pos_x) * 64'(ax) + 64'(it.pos_y) * 64'(ay)
					+ 64'(it.pos_z) * 64'(az) - 64'(offset_q) * 64'sd16384;
				if (scale_q == 0) begin
					bin = 0;
				end else if (proj_d < 0) begin
					return;
				end else begin
					ud = proj_d;
					prod = {32'd0, ud} * {64'd0, scale_q};
					bin = 64'(prod[95:46]);
				end
				lim = (bins_used < NBINS) ? 64'(bins_used) : 64'(NBINS);
				if (bin >= lim) return;
				sum_x[bin] = add_sat(sum_x[bin], $signed({32'd0, it.weight}) * 64'(it.value_x));
				sum_y[bin] = add_sat(sum_y[bin], $signed({32'd0, it.weight}) * 64'(it.value_y));
				sum_z[bin] = add_sat(sum_z[bin], $signed({32'd0, it.weight}) * 64'(it.value_z));
				wt = {1'b0, wsum[bin]} + it.weight;
				wsum[bin] = wt[48] ? 48'hFFFF_FFFF_FFFF : wt[47:0];
			end
			OP_READ: begin
				tot = wsum[it.read_index];
				r.bin_number = it.read_index;
				r.bin_valid = (tot != 0);
				r.mean_x = bin_mean(sum_x[it.read_index], tot);
				r.mean_y = bin_mean(sum_y[it.read_index], tot);
				r.mean_z = bin_mean(sum_z[it.read_index], tot);
				r.total_weight = tot;
				expected_reads.push_back(r);
			end
			OP_CLEAR: begin
				sum_x[it.read_index] = 0;
				sum_y[it.read_index] = 0;
				sum_z[it.read_index] = 0;
				wsum[it.read_index] = 0;
			end
			default: ;
		endcase
	endtask

	// Sender: bursts of random length with random gaps, plus a pause request that
	// holds off until every expected read has returned.
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
			accepted_cnt <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_beat(in_data);
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!in_valid || in_ready) begin
				if (pause_req || pending_items.size() == 0) begin
					in_valid <= 1'b0;
				end else if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else begin
					in_valid <= 1'b1;
					in_data <= pending_items.pop_front();
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 30);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// Receiver: stalls follow a pattern of its own, with quiet stretches.
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= (stall_phase + 1) % 400;
			if (stall_phase < 120) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 2) != 0);
		end
	end

	// Monitor: compare each result beat with the oldest prediction.
	always @(posedge clk) begin
		item_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", out_data);
			end else begin
				e = expected_reads.pop_front();
				if (out_data.bin_number !== e.bin_number || out_data.bin_valid !== e.bin_valid
						|| out_data.mean_x !== e.mean_x || out_data.mean_y !== e.mean_y
						|| out_data.mean_z !== e.mean_z
						|| out_data.total_weight !== e.total_weight) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", e, out_data);
				end
			end
		end
	end

	function automatic logic [31:0] rand_edge32();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	// Builds a random item of the given operation, with edge values mixed into its fields.
	function automatic item_in_t make_item(logic [1:0] op);
		item_in_t it;
		it.operation = op;
		it.pos_x = ($urandom_range(0, 9) == 0) ? rand_edge32() : $urandom;
		it.pos_y = ($urandom_range(0, 9) == 0) ? rand_edge32() : $urandom;
		it.pos_z = ($urandom_range(0, 9) == 0) ? rand_edge32() : $urandom;
		it.weight = ($urandom_range(0, 7) == 0) ? rand_edge32() : $urandom_range(0, 32'h3_0000);
		it.value_x = ($urandom_range(0, 7) == 0) ? rand_edge32() : $urandom;
		it.value_y = ($urandom_range(0, 7) == 0) ? rand_edge32() : $urandom;
		it.value_z = ($urandom_range(0, 7) == 0) ? rand_edge32() : $urandom;
		it.read_index = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
		return it;
	endfunction

	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_reads.size() != 0)
			@(posedge clk);
		// An accumulate may still be in flight; let it finish.
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_AXIS_X: ax = val[15:0];
			CFG_AXIS_Y: ay = val[15:0];
			CFG_AXIS_Z: az = val[15:0];
			CFG_OFFSET: offset_q = val;
			CFG_SCALE:  scale_q = val;
			CFG_BINS:   bins_used = val[8:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] x, logic [15:0] y, logic [15:0] z,
			logic [31:0] off, logic [31:0] sc, logic [8:0] nb);
		write_reg(CFG_AXIS_X, {16'd0, x});
		write_reg(CFG_AXIS_Y, {16'd0, y});
		write_reg(CFG_AXIS_Z, {16'd0, z});
		write_reg(CFG_OFFSET, off);
		write_reg(CFG_SCALE, sc);
		write_reg(CFG_BINS, {23'd0, nb});
	endtask

	// Mostly accumulates near the active bins, with reads and clears mixed in.
	task automatic queue_random(int n);
		item_in_t it;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 60) begin
				it = make_item(OP_ACC);
				if ($urandom_range(0, 3) != 0) begin
					it.pos_x = $urandom_range(0, 32'h0010_0000);
					it.pos_y = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
					it.pos_z = $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
				end
			end else if (k < 85) begin
				it = make_item(OP_READ);
			end else if (k < 95) begin
				it = make_item(OP_CLEAR);
			end else begin
				it = make_item(2'd3);
			end
			pending_items.push_back(it);
		end
	endtask

	initial begin
		item_in_t it;
		ax = 16'sd16384; ay = 0; az = 0;
		offset_q = 0; scale_q = 32'd65536; bins_used = 9'd256;
		for (int b = 0; b < NBINS; b++) begin
			sum_x[b] = 0; sum_y[b] = 0; sum_z[b] = 0; wsum[b] = 0;
		end
		mismatches = 0;
		pause_req = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes of the sums and the weight, all operations, odd codes.
		it = make_item(OP_READ); it.read_index = 8'd0; pending_items.push_back(it);
		for (int i = 0; i < 4; i++) begin
			it = make_item(OP_ACC);
			it.pos_x = 32'sh0000_8000; it.pos_y = 0; it.pos_z = 0;
			it.weight = 32'hFFFF_FFFF;
			it.value_x = 32'sh7FFF_FFFF; it.value_y = 32'sh8000_0000; it.value_z = 0;
			pending_items.push_back(it);
		end
		it = make_item(OP_READ); it.read_index = 8'd0; pending_items.push_back(it);
		it = make_item(OP_ACC); it.pos_x = 32'sh00FF_8000; it.pos_y = 0; it.pos_z = 0;
		it.weight = 32'd1; it.value_x = 32'sh8000_0000; pending_items.push_back(it);
		it = make_item(OP_READ); it.read_index = 8'd255; pending_items.push_back(it);
		it = make_item(OP_ACC); it.pos_x = 32'sh8000_0000; pending_items.push_back(it);
		it = make_item(OP_ACC); it.pos_x = 32'sh7FFF_FFFF; pending_items.push_back(it);
		it = make_item(2'd3); pending_items.push_back(it);
		it = make_item(OP_CLEAR); it.read_index = 8'd0; pending_items.push_back(it);
		it = make_item(OP_READ); it.read_index = 8'd0; pending_items.push_back(it);
		wait_idle();

		// Zero scale sends everything to bin 0; large weights add up in the 48-bit total.
		set_config(16'h0000, 16'h4000, 16'hC000, 32'h8000_0000, 32'd0, 9'd1);
		for (int i = 0; i < 12; i++) begin
			it = make_item(OP_ACC); it.weight = 32'hFFFF_FFFF; pending_items.push_back(it);
		end
		it = make_item(OP_READ); it.read_index = 8'd0; pending_items.push_back(it);
		wait_idle();

		// Zero active bins drops every sample.
		set_config(16'h4000, 16'h0000, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 9'd0);
		queue_random(40);
		wait_idle();

		// Random phases across several settings, extremes among them.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_config(16'h4000, 16'h0000, 16'h0000, 32'h0, 32'h0008_0000, 9'd16);
				1: set_config(16'hC000, 16'h0000, 16'h0000, 32'hFFF0_0000, 32'h0001_0000, 9'd256);
				2: set_config(16'h2D41, 16'h2D41, 16'h0000, 32'h0000_8000, 32'h0004_0000, 9'd300);
				3: set_config(16'h0000, 16'h0000, 16'h4000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 9'd511);
				4: set_config(16'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom,
					9'($urandom));
				default: set_config(16'h4000, 16'h0000, 16'h0000, 32'h0, 32'h0010_0000, 9'd8);
			endcase
			queue_random(160);
			if (ph == 2) begin
				// Hold the sender until every read so far has come back.
				while (pending_items.size() > 80) @(posedge clk);
				pause_req = 1'b1;
				while (in_valid || expected_reads.size() != 0) @(posedge clk);
				pause_req = 1'b0;
			end
			wait_idle();
		end

		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_reads.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
